/* hw/rtl/grf_pkg.sv */
`timescale 1ns / 1ps

package grf_pkg;

  localparam int unsigned GapW      = 8;
  localparam int unsigned LenW      = 12;
  localparam int unsigned DupW      = 7;
  localparam int unsigned SeenDepth = 4096;
  localparam int unsigned SeenAw    = 12;
  localparam int unsigned EpochW    = 8;

  localparam logic [DupW-1:0]   DupMax     = 7'd127;
  localparam logic [EpochW-1:0] EpochFirst = 8'd1;
  localparam logic [EpochW-1:0] EpochLast  = 8'hFF;

  typedef logic [LenW-1:0]   len_t;
  typedef logic [DupW-1:0]   dup_t;
  typedef logic [EpochW-1:0] epoch_t;

endpackage

/* hw/rtl/golomb_ruler_fitness.sv */
// A gap keeps the block busy while it reads the distance bitmap once per earlier
// mark, with two pipeline stages behind the reads; a last gap then enters a finish
// state that waits for a free output, and the result is registered from there.
// No new gap is accepted before the last is through. The walk over earlier marks
// sets the rate. Reset, and the wrap of the 8-bit epoch tag every 255 rulers, start
// a clearing pass over all 4096 entries of the distance memory, taking no gap.
`timescale 1ns / 1ps

module golomb_ruler_fitness #(
  parameter int unsigned MAX_MARKS = 16,
  parameter int unsigned MAX_GAP   = 255
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [grf_pkg::GapW-1:0]            s_axis_tdata,   // [7:0] gap
  input  logic                                s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [23:0]                         m_axis_tdata,   // [11:0] ruler_length,
                                                              // [18:12] duplicate_count
  output logic                                m_axis_tuser    // [0] overflow
);

  localparam int unsigned IW = (MAX_MARKS > 1) ? $clog2(MAX_MARKS) : 1;
  localparam int unsigned HW = $clog2(MAX_MARKS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;
  localparam logic [1:0] ST_CLR  = 2'd3;

  logic [1:0] state_q, state_d;
  logic [HW-1:0] held_q, held_d;
  logic [HW-1:0] k_q, k_d;
  grf_pkg::len_t running_q, running_d;
  grf_pkg::dup_t dup_q, dup_d;
  logic ovf_q, ovf_d;
  logic last_q, last_d;
  grf_pkg::epoch_t epoch_q, epoch_d;
  logic [grf_pkg::SeenAw-1:0] clr_q, clr_d;

  logic s1_v_q, s1_v_d, s1_zero_q;
  logic s2_v_q, s2_v_d, s2_fwd_q, s2_fwd_d;
  logic [grf_pkg::SeenAw-1:0] s2_d_q, d1;

  grf_pkg::len_t mark_mem [MAX_MARKS];
  grf_pkg::len_t mark_rdata_q;
  grf_pkg::epoch_t seen_mem [grf_pkg::SeenDepth];
  grf_pkg::epoch_t seen_rdata_q;

  logic m_valid_q;
  grf_pkg::len_t out_len_q;
  grf_pkg::dup_t out_dup_q;
  logic out_ovf_q;

  logic accept, full, issue, out_free, seen, walk_done;
  logic [grf_pkg::GapW-1:0] gap_c;
  grf_pkg::len_t pos;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign full          = (held_q == HW'(MAX_MARKS));
  assign gap_c = (17'(s_axis_tdata) > 17'(MAX_GAP)) ? grf_pkg::GapW'(MAX_GAP) : s_axis_tdata;
  assign pos           = running_q + grf_pkg::LenW'(gap_c);
  assign issue         = (state_q == ST_WALK) && (k_q != held_q - HW'(1));
  assign walk_done     = (state_q == ST_WALK) && !issue && !s1_v_q && !s2_v_q;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign d1            = s1_zero_q ? running_q : running_q - mark_rdata_q;
  assign seen          = (seen_rdata_q == epoch_q) || s2_fwd_q;

  always_comb begin
    state_d   = state_q;
    held_d    = held_q;
    k_d       = k_q;
    running_d = running_q;
    dup_d     = dup_q;
    ovf_d     = ovf_q;
    last_d    = last_q;
    epoch_d   = epoch_q;
    clr_d     = clr_q;
    s1_v_d    = issue;
    s2_v_d    = s1_v_q;
    s2_fwd_d  = s1_v_q && s2_v_q && (s2_d_q == d1);

    if (s2_v_q && seen && (dup_q != grf_pkg::DupMax)) begin
      dup_d = dup_q + grf_pkg::DupW'(1);
    end
    if (issue) begin
      k_d = k_q + HW'(1);
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          last_d = s_axis_tlast;
          if (full) begin
            ovf_d   = 1'b1;
            state_d = s_axis_tlast ? ST_FIN : ST_IDLE;
          end else begin
            running_d = pos;
            held_d    = held_q + HW'(1);
            k_d       = '0;
            state_d   = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (walk_done) begin
          state_d = last_q ? ST_FIN : ST_IDLE;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          running_d = '0;
          held_d    = HW'(1);
          dup_d     = '0;
          ovf_d     = 1'b0;
          if (epoch_q == grf_pkg::EpochLast) begin
            epoch_d = grf_pkg::EpochFirst;
            clr_d   = '0;
            state_d = ST_CLR;
          end else begin
            epoch_d = epoch_q + grf_pkg::EpochW'(1);
            state_d = ST_IDLE;
          end
        end
      end
      ST_CLR: begin
        clr_d = clr_q + grf_pkg::SeenAw'(1);
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLR;
      held_q    <= HW'(1);
      k_q       <= '0;
      running_q <= '0;
      dup_q     <= '0;
      ovf_q     <= 1'b0;
      last_q    <= 1'b0;
      epoch_q   <= grf_pkg::EpochFirst;
      clr_q     <= '0;
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      held_q    <= held_d;
      k_q       <= k_d;
      running_q <= running_d;
      dup_q     <= dup_d;
      ovf_q     <= ovf_d;
      last_q    <= last_d;
      epoch_q   <= epoch_d;
      clr_q     <= clr_d;
      s1_v_q    <= s1_v_d;
      s2_v_q    <= s2_v_d;
      if (state_q == ST_FIN && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_zero_q <= (k_q == '0);
    s2_d_q    <= d1;
    s2_fwd_q  <= s2_fwd_d;
    if (state_q == ST_FIN && out_free) begin
      out_len_q <= running_q;
      out_dup_q <= dup_q;
      out_ovf_q <= ovf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !full) begin
      mark_mem[held_q[IW-1:0]] <= pos;
    end
    mark_rdata_q <= mark_mem[k_q[IW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLR) begin
      seen_mem[clr_q] <= '0;
    end else if (s2_v_q) begin
      seen_mem[s2_d_q] <= epoch_q;
    end
    seen_rdata_q <= seen_mem[d1];
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {5'd0, out_dup_q, out_len_q};
  assign m_axis_tuser  = out_ovf_q;

  a_pipe_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q || s2_v_q) |-> (state_q == ST_WALK))
    else $error("Distance pipeline busy outside the walk.");

  a_held_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q >= HW'(1)) && (held_q <= HW'(MAX_MARKS)))
    else $error("Mark count out of range.");

  a_finish_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && out_free) |=>
      (m_valid_q && held_q == HW'(1) && running_q == '0 && dup_q == '0 && !ovf_q))
    else $error("Ruler end did not emit a result and clear the state.");

  a_clear_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLR && clr_q == '1) |=>
      (state_q == ST_IDLE && epoch_q == grf_pkg::EpochFirst))
    else $error("Clearing pass ended badly.");

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb;

  localparam int unsigned MarkSlots = 16;
  localparam int unsigned GapCap    = 255;
  localparam int unsigned RandGaps  = 650;
  localparam int unsigned CalmTail  = 80;

  typedef struct {
    logic [grf_pkg::GapW-1:0] gap;
    logic                     last;
    logic                     drain;
  } gap_item_t;

  typedef struct {
    grf_pkg::len_t ruler_length;
    grf_pkg::dup_t duplicate_count;
    logic          overflow;
  } ruler_score_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic        m_axis_tuser;

  gap_item_t    gap_queue[$];
  ruler_score_t scores_due[$];

  grf_pkg::len_t   mark_pos [MarkSlots];
  logic [4095:0]   seen_dist;
  grf_pkg::len_t   ruler_len;
  int unsigned     marks_held;
  grf_pkg::dup_t   dup_tally;
  logic            overflow_hit;

  int unsigned mismatches = 0;
  int unsigned gaps_sent = 0;
  int unsigned scores_seen = 0;
  int          send_idle = 0;
  int          recv_idle = 0;
  logic        gap_taken = 1'b0;

  golomb_ruler_fitness #(
    .MAX_MARKS(MarkSlots),
    .MAX_GAP  (GapCap)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  task automatic clear_ruler();
    seen_dist    = '0;
    ruler_len    = '0;
    marks_held   = 1;
    dup_tally    = '0;
    overflow_hit = 1'b0;
    mark_pos[0]  = '0;
  endtask

  task automatic score_gap(input logic [grf_pkg::GapW-1:0] gap, input logic last);
    int unsigned   step;
    grf_pkg::len_t pos;
    grf_pkg::len_t span;
    ruler_score_t  score;
    step = (gap > GapCap) ? GapCap : gap;
    if (marks_held >= MarkSlots) begin
      overflow_hit = 1'b1;
    end else begin
      pos = ruler_len + grf_pkg::len_t'(step);
      for (int k = 0; k < marks_held; k++) begin
        span = pos - mark_pos[k];
        if (seen_dist[span]) begin
          if (dup_tally != grf_pkg::DupMax) begin
            dup_tally = dup_tally + 1'b1;
          end
        end else begin
          seen_dist[span] = 1'b1;
        end
      end
      mark_pos[marks_held] = pos;
      marks_held++;
      ruler_len = pos;
    end
    if (last) begin
      score.ruler_length    = ruler_len;
      score.duplicate_count = dup_tally;
      score.overflow        = overflow_hit;
      scores_due.insert(scores_due.size(), score);
      clear_ruler();
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch at %0t: %s got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic queue_gap(input int unsigned gap, input logic last, input logic drain);
    gap_item_t item;
    item.gap   = gap[grf_pkg::GapW-1:0];
    item.last  = last;
    item.drain = drain;
    gap_queue.insert(gap_queue.size(), item);
  endtask

  function automatic bit send_may_idle();
    return gap_queue.size() > CalmTail && (gaps_sent / 50) % 3 != 2;
  endfunction

  function automatic bit recv_may_idle();
    return gap_queue.size() > CalmTail && (scores_seen / 8) % 3 != 2;
  endfunction

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (s_axis_tvalid && !gap_taken) begin
    end else if (send_idle != 0) begin
      s_axis_tvalid <= 1'b0;
      send_idle = send_idle - 1;
    end else if (gap_queue.size() == 0 || (gap_queue[0].drain && scores_due.size() != 0)) begin
      s_axis_tvalid <= 1'b0;
    end else if (send_may_idle() && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      send_idle = $urandom_range(0, 18);
    end else begin
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= gap_queue[0].gap;
      s_axis_tlast  <= gap_queue[0].last;
    end
  end

  always @(posedge clk_i) begin
    gap_taken <= s_axis_tvalid && s_axis_tready;
    if (s_axis_tvalid && s_axis_tready) begin
      score_gap(s_axis_tdata, s_axis_tlast);
      void'(gap_queue.pop_front());
      gaps_sent++;
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (recv_idle != 0) begin
      m_axis_tready <= 1'b0;
      recv_idle = recv_idle - 1;
    end else if (recv_may_idle() && $urandom_range(0, 4) == 0) begin
      m_axis_tready <= 1'b0;
      recv_idle = $urandom_range(0, 18);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    ruler_score_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      scores_seen++;
      if (scores_due.size() == 0) begin
        report_mismatch("unexpected result, ruler_length", m_axis_tdata[11:0], 0);
      end else begin
        want = scores_due.pop_front();
        if (m_axis_tdata[11:0] !== want.ruler_length) begin
          report_mismatch("ruler_length", m_axis_tdata[11:0], want.ruler_length);
        end
        if (m_axis_tdata[18:12] !== want.duplicate_count) begin
          report_mismatch("duplicate_count", m_axis_tdata[18:12], want.duplicate_count);
        end
        if (m_axis_tuser !== want.overflow) begin
          report_mismatch("overflow", m_axis_tuser, want.overflow);
        end
      end
    end
  end

  initial begin
    int unsigned random_gaps;
    int unsigned ruler_gaps;
    int unsigned pick;
    int unsigned style;
    int unsigned gap;
    int unsigned ruler_count;
    clear_ruler();

    queue_gap(255, 1'b1, 1'b0);
    queue_gap(0, 1'b1, 1'b0);
    queue_gap(0, 1'b0, 1'b0);
    queue_gap(0, 1'b1, 1'b0);
    queue_gap(1, 1'b0, 1'b0);
    queue_gap(1, 1'b0, 1'b0);
    queue_gap(1, 1'b1, 1'b0);
    for (int i = 0; i < 16; i++) begin
      queue_gap(255, i == 15, 1'b0);
    end

    random_gaps = 0;
    ruler_count = 0;
    while (random_gaps < RandGaps) begin
      pick = $urandom_range(0, 19);
      if (pick < 8) begin
        ruler_gaps = $urandom_range(1, 3);
      end else if (pick < 15) begin
        ruler_gaps = $urandom_range(4, 10);
      end else if (pick < 18) begin
        ruler_gaps = $urandom_range(11, 15);
      end else begin
        ruler_gaps = $urandom_range(16, 19);
      end
      style = $urandom_range(0, 2);
      for (int i = 0; i < ruler_gaps; i++) begin
        if (style == 0 || (style == 2 && $urandom_range(0, 1) == 0)) begin
          gap = $urandom_range(0, 255);
        end else begin
          gap = $urandom_range(0, 7);
        end
        queue_gap(gap, i == ruler_gaps - 1, i == 0 && ruler_count % 40 == 0);
      end
      random_gaps += ruler_gaps;
      ruler_count++;
    end

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (gap_queue.size() != 0) @(posedge clk_i);
    while (scores_due.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/grf_pkg.sv
hw/rtl/golomb_ruler_fitness.sv
sim/tb.sv
